// ===== hdl/crc16_packet_deframer_macros.svh =====
`ifndef CRC16_PACKET_DEFRAMER_MACROS_SVH
`define CRC16_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define CRCDF_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crcdf check failed");

// Next-cycle implication, clocked on clock, off during reset.
`define CRCDF_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crcdf check failed");

`endif

// ===== hdl/crcdf_pkg.sv =====
`timescale 1ns / 1ps

package crcdf_pkg;

   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH = 1'b1;

   localparam logic [7:0]  START_BYTE_RESET = 8'hA1;
   localparam logic [7:0]  MAX_LENGTH_RESET = 8'd200;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_TYPE    = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_CRC_LO  = 3'd3,
      PH_CRC_HI  = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] packet_type;
      logic [7:0] packet_length;
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last;
      logic       crc_ok;
   } result_type;

   // X.25 / MCRF4XX byte update, reflected
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [7:0]  b;
      logic [15:0] r;
      b = data ^ crc[7:0];
      b = b ^ {b[3:0], 4'b0000};
      r = {b, crc[15:8]};
      r = r ^ {12'h000, b[7:4]} ^ {5'b00000, b, 3'b000};
      return r;
   endfunction

endpackage

// ===== hdl/crcdf_engine.sv =====
`timescale 1ns / 1ps

module crcdf_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  crcdf_pkg::cfg_type    cfg,
   output logic                 emit,
   output crcdf_pkg::result_type result
);
   import crcdf_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_length_ff, held_length_in;
   logic [15:0] received_crc_ff, received_crc_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  payload_count_ff, payload_count_in;

   logic [15:0] crc_next;
   logic [7:0]  count_inc;
   logic [15:0] crc_hi_full;
   logic        fin;
   logic        has_result;

   assign crc_next    = crc_byte(running_crc_ff, data_byte);
   assign count_inc   = payload_count_ff + 8'd1;
   assign fin         = (count_inc >= held_length_ff);
   assign crc_hi_full = {data_byte, received_crc_ff[7:0]};

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_TYPE: begin
            if (data_byte != 8'd0) phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            phase_in = (data_byte > cfg.max_length) ? PH_IDLE : PH_CRC_LO;
         end
         PH_CRC_LO: phase_in = PH_CRC_HI;
         PH_CRC_HI: begin
            phase_in = (held_length_ff != 8'd0) ? PH_PAYLOAD : PH_IDLE;
         end
         PH_PAYLOAD: begin
            if (fin) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = (data_byte == cfg.start_byte) ? PH_TYPE : PH_IDLE;
         end
      endcase
   end

   always_comb begin
      held_type_in     = held_type_ff;
      held_length_in   = held_length_ff;
      received_crc_in  = received_crc_ff;
      running_crc_in   = running_crc_ff;
      payload_count_in = payload_count_ff;
      has_result       = 1'b0;
      result.packet_type   = held_type_ff;
      result.packet_length = held_length_ff;
      result.payload_byte  = 8'd0;
      result.has_byte      = 1'b0;
      result.last          = 1'b0;
      result.crc_ok        = 1'b0;
      unique case (phase_ff)
         PH_TYPE: begin
            if (data_byte != 8'd0) begin
               held_type_in   = data_byte;
               running_crc_in = crc_next;
            end
         end
         PH_LENGTH: begin
            if (data_byte <= cfg.max_length) begin
               held_length_in = data_byte;
               running_crc_in = crc_next;
            end
         end
         PH_CRC_LO: received_crc_in = {8'd0, data_byte};
         PH_CRC_HI: begin
            received_crc_in = crc_hi_full;
            if (held_length_ff == 8'd0) begin
               has_result    = 1'b1;
               result.last   = 1'b1;
               result.crc_ok = (crc_hi_full == running_crc_ff);
            end
         end
         PH_PAYLOAD: begin
            running_crc_in      = crc_next;
            payload_count_in    = count_inc;
            has_result          = 1'b1;
            result.payload_byte = data_byte;
            result.has_byte     = 1'b1;
            result.last         = fin;
            result.crc_ok       = fin && (received_crc_ff == crc_next);
         end
         default: begin
            if (data_byte == cfg.start_byte) begin
               running_crc_in   = CRC_INIT;
               payload_count_in = 8'd0;
            end
         end
      endcase
   end

   assign emit = step && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         held_type_ff     <= 8'd0;
         held_length_ff   <= 8'd0;
         received_crc_ff  <= 16'd0;
         running_crc_ff   <= CRC_INIT;
         payload_count_ff <= 8'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         held_type_ff     <= held_type_in;
         held_length_ff   <= held_length_in;
         received_crc_ff  <= received_crc_in;
         running_crc_ff   <= running_crc_in;
         payload_count_ff <= payload_count_in;
      end
   end

`include "crc16_packet_deframer_macros.svh"

   `CRCDF_CHECK_NEXT(a_count_advances, step && (phase_ff == PH_PAYLOAD), payload_count_ff == 8'($past(payload_count_ff) + 8'd1))
   `CRCDF_CHECK(a_empty_from_crc_hi, emit && !result.has_byte, phase_ff == PH_CRC_HI)
   `CRCDF_CHECK(a_ok_only_on_last, result.crc_ok, result.last)

endmodule

// ===== hdl/crc16_packet_deframer.sv =====
`timescale 1ns / 1ps
// channel  | ports                          | beat
// req      | req_valid, req_stall, req_*    | one received byte
// rsp      | rsp_valid, rsp_stall, rsp_*    | one payload byte or empty-packet marker
// csr      | csr_write, csr_index, csr_wdata| one register write
//
// One byte per cycle when not stalled; a byte passes input register, parser, result register.
// Parser state (phase, CRC, counts) updates in the single cycle a byte leaves the input register.
// Synchronous active-high reset; no clearing pass, req_stall is low straight out of reset.
// rsp_stall holds the result register; the input register still takes a byte while
// the result register is free or drains in that cycle.

module crc16_packet_deframer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_packet_type,
   output logic [7:0]                       rsp_packet_length,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_has_byte,
   output logic                             rsp_last,
   output logic                             rsp_crc_ok,
   input  logic                             csr_write,
   input  logic [crcdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                       csr_wdata
);
   import crcdf_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   result_type rsp_result_ff;

   logic       out_free;
   logic       advance;
   logic       produce;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= START_BYTE_RESET;
         cfg_ff.max_length <= MAX_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_BYTE: cfg_ff.start_byte <= csr_wdata;
            CSR_MAX_LENGTH: cfg_ff.max_length <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) in_byte_ff <= req_data_byte;
   end

   crcdf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .cfg       (cfg_ff),
      .emit      (produce),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= produce;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && produce) rsp_result_ff <= result;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_type   = rsp_result_ff.packet_type;
   assign rsp_packet_length = rsp_result_ff.packet_length;
   assign rsp_payload_byte  = rsp_result_ff.payload_byte;
   assign rsp_has_byte      = rsp_result_ff.has_byte;
   assign rsp_last          = rsp_result_ff.last;
   assign rsp_crc_ok        = rsp_result_ff.crc_ok;

`include "crc16_packet_deframer_macros.svh"

   `CRCDF_CHECK(a_stall_needs_item, req_stall, in_valid_ff)
   `CRCDF_CHECK(a_drain_when_empty, in_valid_ff && !rsp_valid_ff, !req_stall)
   `CRCDF_CHECK_NEXT(a_rsp_clears, rsp_valid && !rsp_stall && !produce, !rsp_valid)
   `CRCDF_CHECK(a_mid_has_byte, produce && !result.last, result.has_byte)

endmodule

// ===== bench/crc16_packet_deframer_tb.sv =====
`timescale 1ns / 1ps

module crc16_packet_deframer_tb;
   import crcdf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned WHOLE       = 1000;
   localparam int unsigned RANDOM_BYTES = 1040;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_packet_type;
   logic [7:0]             rsp_packet_length;
   logic [7:0]             rsp_payload_byte;
   logic                   rsp_has_byte;
   logic                   rsp_last;
   logic                   rsp_crc_ok;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_START_BYTE;
   logic [7:0]             csr_wdata = 8'h00;

   // deframer state and register copies
   phase_type   dec_phase = PH_IDLE;
   logic [7:0]  dec_type = 8'h00;
   logic [7:0]  dec_length = 8'h00;
   logic [15:0] dec_rx_crc = 16'h0000;
   logic [15:0] dec_crc = CRC_INIT;
   logic [7:0]  dec_count = 8'h00;
   logic [7:0]  cfg_start = START_BYTE_RESET;
   logic [7:0]  cfg_max = MAX_LENGTH_RESET;

   result_type  due_results[$];
   logic [7:0]  body[$];
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;

   crc16_packet_deframer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_packet_type   (rsp_packet_type),
      .rsp_packet_length (rsp_packet_length),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_has_byte      (rsp_has_byte),
      .rsp_last          (rsp_last),
      .rsp_crc_ok        (rsp_crc_ok),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL crc16_packet_deframer");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 28);
   end

   // reflected CRC-16, polynomial 0x8408, one bit at a time
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] x;
      x = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         x = x[0] ? ((x >> 1) ^ 16'h8408) : (x >> 1);
      end
      return x;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      case (dec_phase)
         PH_TYPE: begin
            if (b != 8'h00) begin
               dec_type = b;
               dec_crc = crc16_step(dec_crc, b);
               dec_phase = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            if (b > cfg_max) begin
               dec_phase = PH_IDLE;
            end else begin
               dec_length = b;
               dec_crc = crc16_step(dec_crc, b);
               dec_phase = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            dec_rx_crc = {8'h00, b};
            dec_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            dec_rx_crc[15:8] = b;
            if (dec_length != 8'h00) begin
               dec_phase = PH_PAYLOAD;
            end else begin
               dec_phase = PH_IDLE;
               r.packet_type = dec_type;
               r.packet_length = dec_length;
               r.last = 1'b1;
               r.crc_ok = (dec_rx_crc == dec_crc);
               due_results.push_back(r);
            end
         end
         PH_PAYLOAD: begin
            dec_crc = crc16_step(dec_crc, b);
            dec_count = dec_count + 8'd1;
            r.packet_type = dec_type;
            r.packet_length = dec_length;
            r.payload_byte = b;
            r.has_byte = 1'b1;
            r.last = (dec_count >= dec_length);
            r.crc_ok = r.last && (dec_rx_crc == dec_crc);
            if (r.last) dec_phase = PH_IDLE;
            due_results.push_back(r);
         end
         default: begin
            dec_phase = PH_IDLE;
            if (b == cfg_start) begin
               dec_crc = CRC_INIT;
               dec_count = 8'h00;
               dec_phase = PH_TYPE;
            end
         end
      endcase
   endfunction

   function automatic string beat_text(input result_type r);
      return $sformatf("type %h len %h byte %h has %b last %b ok %b", r.packet_type,
                       r.packet_length, r.payload_byte, r.has_byte, r.last, r.crc_ok);
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   always @(posedge clock) begin : result_check
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_packet_type, rsp_packet_length, rsp_payload_byte,
                 rsp_has_byte, rsp_last, rsp_crc_ok};
         if (due_results.size() == 0) begin
            flag_error($sformatf("%0t: unexpected beat: %s", $time, beat_text(seen)));
         end else begin
            want = due_results.pop_front();
            if (seen.packet_type !== want.packet_type ||
                seen.packet_length !== want.packet_length ||
                seen.payload_byte !== want.payload_byte ||
                seen.has_byte !== want.has_byte ||
                seen.last !== want.last ||
                seen.crc_ok !== want.crc_ok)
               flag_error($sformatf("%0t: expected %s, got %s", $time,
                                    beat_text(want), beat_text(seen)));
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      deframe_byte(value);
      items_sent++;
   endtask

   // hold the sender until every expected beat is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_START_BYTE) cfg_start = value;
      else cfg_max = value;
   endtask

   function automatic void fill_body(input int unsigned n);
      body.delete();
      repeat (n) body.push_back(8'($urandom));
   endfunction

   function automatic logic [15:0] packet_crc(input logic [7:0] ptype);
      logic [15:0] c;
      c = crc16_step(CRC_INIT, ptype);
      c = crc16_step(c, 8'(body.size()));
      foreach (body[i]) c = crc16_step(c, body[i]);
      return c;
   endfunction

   task automatic send_packet(input logic [7:0] ptype, input logic [15:0] crc_flip,
                              input int unsigned zero_types, input int unsigned keep);
      logic [15:0] c;
      logic [7:0]  frame[$];
      c = packet_crc(ptype) ^ crc_flip;
      frame.push_back(cfg_start);
      repeat (zero_types) frame.push_back(8'h00);
      frame.push_back(ptype);
      frame.push_back(8'(body.size()));
      frame.push_back(c[7:0]);
      frame.push_back(c[15:8]);
      foreach (body[i]) frame.push_back(body[i]);
      foreach (frame[i]) begin
         if (i < keep) send_byte(frame[i]);
      end
   endtask

   task automatic test_directed_cases();
      logic [7:0]  ptype;
      logic [15:0] mask;
      send_byte(8'h00);
      send_byte(8'hFF);
      body.delete();
      send_packet(8'h07, 16'h0000, 1, WHOLE);
      send_byte(cfg_start);
      send_byte(8'h05);
      send_byte(8'hFF);
      // good CRC with a zero low byte, then a zero high byte
      for (int k = 0; k < 2; k++) begin
         mask = (k == 0) ? 16'h00FF : 16'hFF00;
         ptype = 8'($urandom_range(1, 255));
         fill_body(1);
         while ((packet_crc(ptype) & mask) != 16'h0000) begin
            ptype = 8'($urandom_range(1, 255));
            fill_body(1);
         end
         send_packet(ptype, 16'h0000, 0, WHOLE);
      end
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_START_BYTE, 8'h00);
      write_csr(CSR_MAX_LENGTH, 8'h00);
      send_byte(8'h5A);
      body.delete();
      send_packet(8'h01, 16'h0000, 0, WHOLE);
      send_packet(8'hFF, 16'h8000, 2, WHOLE);
      send_byte(8'h00);
      send_byte(8'h33);
      send_byte(8'h01);
      write_csr(CSR_START_BYTE, 8'hFF);
      write_csr(CSR_MAX_LENGTH, 8'hFF);
      fill_body(255);
      send_packet(8'h80, 16'h0000, 0, WHOLE);
      fill_body(3);
      send_packet(8'h42, 16'h0001, 0, WHOLE);
   endtask

   task automatic test_random_traffic();
      int unsigned first;
      int unsigned done;
      int unsigned kind;
      int unsigned len;
      logic [7:0]  ptype;
      first = items_sent;
      while (items_sent - first < RANDOM_BYTES) begin
         done = items_sent - first;
         calm = (done >= 500 && done < 750);
         if ($urandom_range(99) < 3) begin
            write_csr(CSR_START_BYTE, 8'($urandom));
            case ($urandom_range(3))
               0: write_csr(CSR_MAX_LENGTH, 8'h00);
               1: write_csr(CSR_MAX_LENGTH, 8'hFF);
               default: write_csr(CSR_MAX_LENGTH, 8'($urandom));
            endcase
         end else if ($urandom_range(99) < 2) begin
            drain();
         end
         kind = $urandom_range(99);
         len = ($urandom_range(99) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 6);
         if (len > cfg_max) len = cfg_max;
         ptype = 8'($urandom_range(1, 255));
         fill_body(len);
         if (kind < 70) begin
            send_packet(ptype, 16'h0000, 0, WHOLE);
         end else if (kind < 80) begin
            send_packet(ptype, 16'h0001 << $urandom_range(15), 0, WHOLE);
         end else if (kind < 86) begin
            send_packet(ptype, 16'h0000, 0, $urandom_range(1, 4 + len));
         end else if (kind < 92) begin
            send_packet(ptype, 16'h0000, $urandom_range(1, 3), WHOLE);
         end else if (kind < 96 && cfg_max != 8'hFF) begin
            send_byte(cfg_start);
            send_byte(ptype);
            send_byte(8'($urandom_range(cfg_max + 1, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_register_extremes();
      test_random_traffic();
      drain();
      if (error_count == 0) $display("PASS crc16_packet_deframer");
      else $display("FAIL crc16_packet_deframer");
      $finish;
   end

endmodule
